// ===== sv/rcba_pkg.sv =====
// rcba_pkg: beat types and command codes of the rotated clipped blit address block.
// Depends on nothing; imported by rotated_clipped_blit_address.
package rcba_pkg;

    localparam int COORD_W = 16;
    localparam int ADDR_W  = 17;
    localparam int COLOR_W = 32;

    localparam logic CMD_OPEN  = 1'b0;
    localparam logic CMD_PIXEL = 1'b1;

    typedef struct packed {
        logic                      command;
        logic signed [COORD_W-1:0] area_x_first;
        logic signed [COORD_W-1:0] area_y_first;
        logic signed [COORD_W-1:0] area_x_last;
        logic signed [COORD_W-1:0] area_y_last;
        logic        [COLOR_W-1:0] pixel_color;
    } t_in;

    typedef struct packed {
        logic               write_enable;
        logic [ADDR_W-1:0]  fb_address;
        logic [COLOR_W-1:0] write_color;
        logic               done_res;
    } t_out;

endpackage

// ===== sv/rotated_clipped_blit_address.sv =====
// rotated_clipped_blit_address: clips a portrait source rectangle and maps its pixels
// to 90-degree-rotated landscape framebuffer writes. Depends on rcba_pkg.
//
// Usage: an input beat with command OPEN carries the area bounds; beats with command
// PIXEL then carry its pixels in row-major order. Each pixel of an open area yields
// one result beat: write_enable with the rotated address and color when the pixel
// lies on the logical screen, else an empty write. done_res marks the last pixel. An
// area whose clipped region is empty yields one result with done_res alone; pixels
// sent while no area is open are dropped.
// Both channels use valid/stall. A result is registered and appears on the output
// in the cycle after its input beat is accepted. One beat is accepted every cycle;
// the single output register frees in the same cycle it is taken, so the input
// stalls only while a result is held by a stalled receiver.
// Per pixel the path is a few compares and one multiply by PHYS_WIDTH.
// Reset closes any open area and empties the output register.
module rotated_clipped_blit_address #(
    parameter int PHYS_WIDTH     = 480,
    parameter int LOGICAL_WIDTH  = 272,
    parameter int LOGICAL_HEIGHT = 480
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_stall,
    input  rcba_pkg::t_in i_in,
    output logic          o_out_valid,
    input  logic          i_out_stall,
    output rcba_pkg::t_out o_out
);
    import rcba_pkg::*;

    localparam int XB_W = (LOGICAL_WIDTH  > 1) ? $clog2(LOGICAL_WIDTH)  : 1;
    localparam int YB_W = (LOGICAL_HEIGHT > 1) ? $clog2(LOGICAL_HEIGHT) : 1;
    localparam int CMP_W = COORD_W + 1;
    localparam logic signed [CMP_W-1:0] LW_S    = CMP_W'(LOGICAL_WIDTH);
    localparam logic signed [CMP_W-1:0] LH_S    = CMP_W'(LOGICAL_HEIGHT);
    localparam logic signed [CMP_W-1:0] LW_M1_S = CMP_W'(LOGICAL_WIDTH - 1);
    localparam logic signed [CMP_W-1:0] LH_M1_S = CMP_W'(LOGICAL_HEIGHT - 1);
    localparam logic [ADDR_W-1:0] PW_A     = ADDR_W'(PHYS_WIDTH);
    localparam logic [ADDR_W-1:0] PW_M1_A  = ADDR_W'(PHYS_WIDTH - 1);

    // area state
    logic                      r_area_open;
    logic signed [COORD_W-1:0] r_x_first, r_x_last, r_y_last;
    logic signed [COORD_W-1:0] r_cur_x, r_cur_y;
    logic        [XB_W-1:0]    r_x_lo, r_x_hi;
    logic        [YB_W-1:0]    r_y_lo, r_y_hi;

    logic r_out_valid;
    t_out r_out;

    logic acc;
    logic res_valid;
    t_out n_out;

    // open-side clipping
    logic signed [CMP_W-1:0] o_xf, o_yf, o_xl, o_yl;
    logic signed [CMP_W-1:0] c_x_lo, c_x_hi, c_y_lo, c_y_hi;
    logic                    empty_area;

    // pixel side
    logic signed [CMP_W-1:0] cx, cy;
    logic px_in, last_px;
    logic [ADDR_W-1:0] row_base, col_off;

    assign o_in_stall = r_out_valid && i_out_stall;
    assign acc        = i_in_valid && !o_in_stall;

    always_comb begin
        o_xf = CMP_W'(i_in.area_x_first);
        o_yf = CMP_W'(i_in.area_y_first);
        o_xl = CMP_W'(i_in.area_x_last);
        o_yl = CMP_W'(i_in.area_y_last);
        c_x_lo = (o_xf < 0) ? '0 : o_xf;
        c_y_lo = (o_yf < 0) ? '0 : o_yf;
        c_x_hi = (o_xl >= LW_S) ? LW_M1_S : o_xl;
        c_y_hi = (o_yl >= LH_S) ? LH_M1_S : o_yl;
        empty_area = (c_x_lo > c_x_hi) || (c_y_lo > c_y_hi);
    end

    always_comb begin
        cx = CMP_W'(r_cur_x);
        cy = CMP_W'(r_cur_y);
        px_in = (cx >= $signed(CMP_W'(r_x_lo))) && (cx <= $signed(CMP_W'(r_x_hi)))
             && (cy >= $signed(CMP_W'(r_y_lo))) && (cy <= $signed(CMP_W'(r_y_hi)));
        last_px  = (r_cur_x == r_x_last) && (r_cur_y == r_y_last);
        row_base = ADDR_W'(ADDR_W'($unsigned(r_cur_x)) * PW_A);
        col_off  = PW_M1_A - ADDR_W'($unsigned(r_cur_y));
    end

    always_comb begin
        n_out = '0;
        res_valid = 1'b0;
        unique case (i_in.command)
            CMD_OPEN: begin
                res_valid      = empty_area;
                n_out.done_res = 1'b1;
            end
            CMD_PIXEL: begin
                res_valid          = r_area_open;
                n_out.write_enable = px_in;
                n_out.fb_address   = px_in ? row_base + col_off : '0;
                n_out.write_color  = px_in ? i_in.pixel_color : '0;
                n_out.done_res     = last_px;
            end
            default: res_valid = 1'b0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_area_open <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (acc) begin
                r_out_valid <= res_valid;
                if (i_in.command == CMD_OPEN) begin
                    r_area_open <= !empty_area;
                end else if (r_area_open && last_px) begin
                    r_area_open <= 1'b0;
                end
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (acc) begin
            r_out <= n_out;
            if (i_in.command == CMD_OPEN) begin
                r_x_first <= i_in.area_x_first;
                r_x_last  <= i_in.area_x_last;
                r_y_last  <= i_in.area_y_last;
                r_cur_x   <= i_in.area_x_first;
                r_cur_y   <= i_in.area_y_first;
                r_x_lo    <= XB_W'(c_x_lo);
                r_x_hi    <= XB_W'(c_x_hi);
                r_y_lo    <= YB_W'(c_y_lo);
                r_y_hi    <= YB_W'(c_y_hi);
            end else if (r_area_open && !last_px) begin
                if (r_cur_x >= r_x_last) begin
                    r_cur_x <= r_x_first;
                    r_cur_y <= r_cur_y + 1'b1;
                end else begin
                    r_cur_x <= r_cur_x + 1'b1;
                end
            end
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

`ifndef SYNTHESIS
    a_empty_write_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_out.write_enable) |-> (o_out.fb_address == '0
            && o_out.write_color == '0))
        else $error("empty write carries address or color");

    a_drop_pixel: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (acc && i_in.command == CMD_PIXEL && !r_area_open) |=> !o_out_valid)
        else $error("pixel with no open area produced a result");

    a_done_closes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (acc && res_valid && n_out.done_res) |=> !r_area_open)
        else $error("area still open after done");

    a_cursor_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_area_open |-> (r_cur_x >= r_x_first && r_cur_x <= r_x_last
            && r_cur_y <= r_y_last))
        else $error("cursor left the open area");
`endif

endmodule
